>>> hdl/tpa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tpa_pkg
// shared types and constants for triangle primitive assembly
// ---------------------------------------------------------------------------
package tpa_pkg;

    localparam int INDEX_BITS = 16;
    localparam int JOB_DEPTH  = 4;
    localparam int JOB_PTR_W  = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W  = $clog2(JOB_DEPTH + 1);

    // command codes
    localparam logic CMD_BEGIN  = 1'b0;
    localparam logic CMD_VERTEX = 1'b1;

    typedef enum logic [1:0] {
        MODE_LIST  = 2'd0,
        MODE_FAN   = 2'd1,
        MODE_STRIP = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef logic [INDEX_BITS-1:0] t_index;

    typedef struct packed {
        logic       command;
        logic [1:0] prim_type;
        t_index     vertex_index;
    } t_in_word;

    typedef struct packed {
        t_index out_index;
        logic   last;
    } t_out_word;

    // one queued job: a single index or a full triangle
    typedef struct packed {
        logic   is_tri;
        t_index idx0;
        t_index idx1;
        t_index idx2;
    } t_job;

    // front to queue
    typedef struct packed {
        logic push;
        t_job job;
    } t_job_push;

    // queue to back
    typedef struct packed {
        logic avail;
        t_job job;
    } t_job_head;

endpackage

>>> hdl/triangle_primitive_assembly.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// triangle_primitive_assembly
// turns a stream of begin and vertex words into a flat triangle index list
// ---------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  input    in         i_in_valid / o_in_stall   i_in_word  (command, type, index)
//  output   out        o_out_valid / i_out_stall o_out_word (out_index, last)
//
//  a begin word or dropped vertex makes no output word
//  list vertices and the first three fan/strip vertices give one word each,
//  one per cycle while the output is not stalled; later fan/strip vertices
//  give three words each, which the single output register sends one at a time
//  synchronous active-low reset leaves no primitive active: vertices are
//  dropped until a begin word arrives
//  a four-job queue lets the input side keep accepting while the output
//  side is stalled; o_in_stall rises only when that queue is full
// ---------------------------------------------------------------------------
module triangle_primitive_assembly (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tpa_pkg::t_in_word  i_in_word,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tpa_pkg::t_out_word o_out_word
);
    import tpa_pkg::*;

    // front to queue: push strobe plus the job it built
    t_job_push push;
    // queue to back: head job and whether one is there
    t_job_head head;
    logic      full;
    logic      pop;

    // input is held off only by a full job queue
    assign o_in_stall = full;

    // front: decodes words, keeps mode, lead count, phase and vertex history
    tpa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .i_full     (full),
        .o_push     (push)
    );

    // queue: decouples front from back
    tpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    // back: steps through one or three indices per job into the output register
    tpa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

>>> hdl/tpa_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tpa_front
// accepts words, tracks primitive state and builds output jobs
// ---------------------------------------------------------------------------
module tpa_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  tpa_pkg::t_in_word  i_in_word,
    input  logic               i_full,
    output tpa_pkg::t_job_push o_push
);
    import tpa_pkg::*;

    t_mode      r_mode, n_mode;
    logic [1:0] r_lead, n_lead;
    logic       r_odd, n_odd;
    t_index     r_first, n_first;
    t_index     r_older, n_older;
    t_index     r_newer, n_newer;

    logic   accept;
    t_index v;

    assign accept = i_in_valid && !i_full;
    assign v      = i_in_word.vertex_index;

    always_comb begin
        n_mode  = r_mode;
        n_lead  = r_lead;
        n_odd   = r_odd;
        n_first = r_first;
        n_older = r_older;
        n_newer = r_newer;
        o_push  = '0;
        if (accept) begin
            if (i_in_word.command == CMD_BEGIN) begin
                n_mode  = t_mode'(i_in_word.prim_type);
                n_lead  = '0;
                n_odd   = 1'b0;
                n_older = '0;
                n_newer = '0;
            end else if (r_mode != MODE_NONE) begin
                o_push.push = 1'b1;
                if (r_mode == MODE_LIST || r_lead != 2'd3) begin
                    o_push.job.is_tri = 1'b0;
                    o_push.job.idx0   = v;
                    if (r_mode != MODE_LIST) begin
                        if (r_lead == 2'd0) begin
                            n_first = v;
                        end
                        if (r_lead == 2'd2) begin
                            n_odd = 1'b1;
                        end
                        n_lead = r_lead + 2'd1;
                    end
                end else if (r_mode == MODE_FAN) begin
                    o_push.job.is_tri = 1'b1;
                    o_push.job.idx0   = r_first;
                    o_push.job.idx1   = r_newer;
                    o_push.job.idx2   = v;
                end else begin
                    o_push.job.is_tri = 1'b1;
                    o_push.job.idx0   = r_older;
                    // winding flips every strip triangle
                    if (r_odd) begin
                        o_push.job.idx1 = v;
                        o_push.job.idx2 = r_newer;
                    end else begin
                        o_push.job.idx1 = r_newer;
                        o_push.job.idx2 = v;
                    end
                    n_odd = !r_odd;
                end
                n_older = r_newer;
                n_newer = v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NONE;
            r_lead  <= '0;
            r_odd   <= 1'b0;
            r_first <= '0;
            r_older <= '0;
            r_newer <= '0;
        end else begin
            r_mode  <= n_mode;
            r_lead  <= n_lead;
            r_odd   <= n_odd;
            r_first <= n_first;
            r_older <= n_older;
            r_newer <= n_newer;
        end
    end

endmodule

>>> hdl/tpa_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tpa_queue
// small job queue between front and back
// ---------------------------------------------------------------------------
module tpa_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tpa_pkg::t_job_push i_push,
    input  logic               i_pop,
    output logic               o_full,
    output tpa_pkg::t_job_head o_head
);
    import tpa_pkg::*;

    t_job                 r_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] r_wr, n_wr;
    logic [JOB_PTR_W-1:0] r_rd, n_rd;
    logic [JOB_CNT_W-1:0] r_count, n_count;

    assign o_full     = (r_count == JOB_CNT_W'(JOB_DEPTH));
    assign o_head.avail = (r_count != '0);
    assign o_head.job = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push.push) begin
            n_wr = r_wr + JOB_PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = r_rd + JOB_PTR_W'(1);
        end
        if (i_push.push && !i_pop) begin
            n_count = r_count + JOB_CNT_W'(1);
        end else if (!i_push.push && i_pop) begin
            n_count = r_count - JOB_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push.push)
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.avail)
        else $error("job popped from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= JOB_CNT_W'(JOB_DEPTH))
        else $error("queue count out of range");

endmodule

>>> hdl/tpa_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tpa_back
// serializes jobs into output words through an output register
// ---------------------------------------------------------------------------
module tpa_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tpa_pkg::t_job_head i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tpa_pkg::t_out_word o_out_word
);
    import tpa_pkg::*;

    t_job       r_job;
    logic       r_job_valid, n_job_valid;
    logic [1:0] r_pos, n_pos;
    logic       r_out_valid, n_out_valid;
    t_out_word  r_out;

    logic   out_free;
    logic   emit;
    logic   is_last;
    t_index sel;

    assign out_free = !r_out_valid || !i_out_stall;
    assign emit     = out_free && r_job_valid;
    assign is_last  = !r_job.is_tri || (r_pos == 2'd2);
    assign o_pop    = i_head.avail && (!r_job_valid || (emit && is_last));

    always_comb begin
        case (r_pos)
            2'd0:    sel = r_job.idx0;
            2'd1:    sel = r_job.idx1;
            default: sel = r_job.idx2;
        endcase
    end

    always_comb begin
        n_job_valid = r_job_valid;
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        if (out_free) begin
            n_out_valid = emit;
        end
        if (emit) begin
            n_pos = r_pos + 2'd1;
            if (is_last) begin
                n_job_valid = 1'b0;
                n_pos       = '0;
            end
        end
        if (o_pop) begin
            n_job_valid = 1'b1;
            n_pos       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head.job;
        end
        if (emit) begin
            r_out.out_index <= sel;
            r_out.last      <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_job_valid <= n_job_valid;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_job_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && !is_last |=> r_job_valid && r_pos == $past(r_pos) + 2'd1)
        else $error("triangle job lost before its last word");

    a_pos_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid && !r_job.is_tri |-> r_pos == 2'd0)
        else $error("single-index job past its first word");

endmodule
